// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/rmat_pkg.sv =====
// shared types and constants for the r-mat edge generator
package rmat_pkg;
  localparam int unsigned MaxScale = 32;
  localparam int unsigned TwN = 312;
  localparam int unsigned TwM = 156;
  localparam int unsigned AddrW = 9;
  localparam int unsigned ScaleW = 6;
  localparam logic [63:0] TwMatrix = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TwUpper = 64'hFFFFFFFF80000000;
  localparam logic [63:0] TwLower = 64'h000000007FFFFFFF;
  localparam logic [63:0] TwInitMul = 64'd6364136223846793005;
  // halves of the seeding multiplier for 32 by 32 partial products
  localparam logic [31:0] TwInitMulLo = 32'h4C957F2D;
  localparam logic [31:0] TwInitMulHi = 32'h5851F42D;

  localparam logic [2:0] RegSeed = 3'd0;
  localparam logic [2:0] RegScale = 3'd1;
  localparam logic [2:0] RegThrA = 3'd2;
  localparam logic [2:0] RegThrAb = 3'd3;
  localparam logic [2:0] RegThrAbc = 3'd4;

  // datapath operations
  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpInitMul,
    OpInitWr,
    OpTwistRd,
    OpTwistWr,
    OpDrawRd,
    OpDrawUse
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] idx;
    logic             clear;
  } dp_cmd_t;

  typedef struct packed {
    logic        self_edge;
  } dp_sts_t;
endpackage

// ===== hw/rtl/rmat_edge_generator.sv =====
// top level of the r-mat edge generator
//  channel  | dir | handshake         | payload
//  s_axis   | in  | tvalid/tready     | tdata[63:0] edge_index
//  m_axis   | out | tvalid/tready     | tdata[31:0] low_vertex, [63:32] high_vertex
//  apb      | in  | psel/penable      | seed, scale, threshold_a/ab/abc
// one edge seeds 311 twister words, twists all 312, then draws min(scale, 32) words;
// seeding and twist each write one twister word per step.
// reset clears control only; the twister words are rewritten for every edge.
// a held result blocks the next edge until it is taken.
`include "assert_macros.svh"
module rmat_edge_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // edge_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // low_vertex, high_vertex
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] seed_q, thr_a_q, thr_ab_q, thr_abc_q;
  logic [5:0]  scale_q;
  logic [2:0]  reg_idx;
  rmat_pkg::dp_cmd_t cmd;
  rmat_pkg::dp_sts_t sts;
  logic [31:0] lo_v, hi_v;

  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      scale_q <= 6'd16;
      thr_a_q <= 64'd10514644122014444421;
      thr_ab_q <= 64'd14019525496019259228;
      thr_abc_q <= 64'd17524406870024074035;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (reg_idx)
        rmat_pkg::RegSeed:   seed_q <= pwdata;
        rmat_pkg::RegScale:  scale_q <= pwdata[5:0];
        rmat_pkg::RegThrA:   thr_a_q <= pwdata;
        rmat_pkg::RegThrAb:  thr_ab_q <= pwdata;
        rmat_pkg::RegThrAbc: thr_abc_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      rmat_pkg::RegSeed:   prdata = seed_q;
      rmat_pkg::RegScale:  prdata = {58'd0, scale_q};
      rmat_pkg::RegThrA:   prdata = thr_a_q;
      rmat_pkg::RegThrAb:  prdata = thr_ab_q;
      rmat_pkg::RegThrAbc: prdata = thr_abc_q;
      default:             prdata = '0;
    endcase
  end

  rmat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .scale_i     (scale_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmat_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .seed_sum_i    (seed_q + s_axis_tdata),
    .thr_a_i       (thr_a_q),
    .thr_ab_i      (thr_ab_q),
    .thr_abc_i     (thr_abc_q),
    .sts_o         (sts),
    .low_vertex_o  (lo_v),
    .high_vertex_o (hi_v)
  );

  assign m_axis_tdata = {hi_v, lo_v};

  `ASSERT_CLK(a_no_accept_busy, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)
  `ASSERT_CLK(a_ordered, clk_i, rst_ni, m_axis_tvalid |-> (lo_v < hi_v))
  `ASSERT_CLK(a_accept_starts, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
endmodule

// ===== hw/rtl/rmat_datapath.sv =====
// datapath: twister word memory, seeding multiply, twist, tempering and vertex build
module rmat_datapath (
  input  logic                  clk_i,
  input  rmat_pkg::dp_cmd_t     cmd_i,
  input  logic [63:0]           seed_sum_i,
  input  logic [63:0]           thr_a_i,
  input  logic [63:0]           thr_ab_i,
  input  logic [63:0]           thr_abc_i,
  output rmat_pkg::dp_sts_t     sts_o,
  output logic [31:0]           low_vertex_o,
  output logic [31:0]           high_vertex_o
);
  logic [63:0] mem [rmat_pkg::TwN];
  logic [63:0] prev_q, prev_d;
  logic [63:0] mix;
  logic [63:0] mul_lo;
  logic [31:0] mul_cross;
  logic [63:0] mul_lo_q;
  logic [31:0] mul_cross_q;
  logic [63:0] init_val;
  logic [63:0] cur_q;
  logic [63:0] rd_a_q, rd_c_q;
  logic [63:0] tw_val;
  logic [63:0] y;
  logic [63:0] x0, x1, x2, x3, x4;
  logic [31:0] src_q, dst_q;
  logic        sb, db;
  logic [rmat_pkg::AddrW-1:0] idx1, idxm, rd_addr;
  logic [rmat_pkg::AddrW:0]   sum1, summ;

  // wrapped neighbor addresses
  assign sum1 = {1'b0, cmd_i.idx} + 10'd1;
  assign summ = {1'b0, cmd_i.idx} + 10'(rmat_pkg::TwM);
  assign idx1 = (sum1 >= 10'(rmat_pkg::TwN)) ? 9'(sum1 - 10'(rmat_pkg::TwN)) : sum1[8:0];
  assign idxm = (summ >= 10'(rmat_pkg::TwN)) ? 9'(summ - 10'(rmat_pkg::TwN)) : summ[8:0];

  // first read port: next word during the twist, drawn word otherwise
  assign rd_addr = (cmd_i.op == rmat_pkg::OpTwistRd) ? idx1 : cmd_i.idx;

  // seeding multiply split into 32 by 32 partial products
  assign mix = prev_q ^ (prev_q >> 62);
  assign mul_lo = {32'd0, mix[31:0]} * {32'd0, rmat_pkg::TwInitMulLo};
  assign mul_cross = 32'(mix[63:32] * rmat_pkg::TwInitMulLo) +
                     32'(mix[31:0] * rmat_pkg::TwInitMulHi);
  assign init_val = mul_lo_q + {mul_cross_q, 32'd0} + 64'(cmd_i.idx);

  // twist word from the held current word and registered reads
  assign y = (cur_q & rmat_pkg::TwUpper) | (rd_a_q & rmat_pkg::TwLower);
  assign tw_val = rd_c_q ^ (y >> 1) ^ (y[0] ? rmat_pkg::TwMatrix : 64'd0);

  // tempering of the drawn word
  assign x0 = rd_a_q;
  assign x1 = x0 ^ ((x0 >> 29) & 64'h5555555555555555);
  assign x2 = x1 ^ ((x1 << 17) & 64'h71D67FFFEDA60000);
  assign x3 = x2 ^ ((x2 << 37) & 64'hFFF7EEE000000000);
  assign x4 = x3 ^ (x3 >> 43);

  // quadrant pick
  always_comb begin
    if (x4 <= thr_a_i) begin
      sb = 1'b0; db = 1'b0;
    end else if (x4 <= thr_ab_i) begin
      sb = 1'b0; db = 1'b1;
    end else if (x4 <= thr_abc_i) begin
      sb = 1'b1; db = 1'b0;
    end else begin
      sb = 1'b1; db = 1'b1;
    end
  end

  // next value of the seeding chain word
  always_comb begin
    prev_d = prev_q;
    case (cmd_i.op)
      rmat_pkg::OpLoad:   prev_d = seed_sum_i;
      rmat_pkg::OpInitWr: prev_d = init_val;
      default:            prev_d = prev_q;
    endcase
  end

  // memory and datapath registers
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    mul_lo_q <= mul_lo;
    mul_cross_q <= mul_cross;
    rd_a_q <= mem[rd_addr];
    rd_c_q <= mem[idxm];
    case (cmd_i.op)
      rmat_pkg::OpLoad: begin
        mem[cmd_i.idx] <= seed_sum_i;
        cur_q <= seed_sum_i;
      end
      rmat_pkg::OpInitWr:  mem[cmd_i.idx] <= init_val;
      rmat_pkg::OpTwistWr: begin
        mem[cmd_i.idx] <= tw_val;
        cur_q <= rd_a_q;
      end
      default: ;
    endcase
    if (cmd_i.clear) begin
      src_q <= '0;
      dst_q <= '0;
    end else if (cmd_i.op == rmat_pkg::OpDrawUse) begin
      src_q <= {src_q[30:0], sb};
      dst_q <= {dst_q[30:0], db};
    end
  end

  assign sts_o.self_edge = (src_q == dst_q);
  assign low_vertex_o  = (src_q < dst_q) ? src_q : dst_q;
  assign high_vertex_o = (src_q < dst_q) ? dst_q : src_q;
endmodule

// ===== hw/rtl/rmat_ctrl.sv =====
// controller: sequences seeding, twist and draws for one edge
module rmat_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [5:0]            scale_i,
  input  rmat_pkg::dp_sts_t     sts_i,
  output rmat_pkg::dp_cmd_t     cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StMul, StInit, StTwRd, StTwWr, StDrRd, StDrUse, StDone
  } state_e;

  state_e state_q;
  logic [rmat_pkg::AddrW-1:0] idx_q;
  logic [5:0] left_q;
  logic [5:0] n_eff;
  logic       out_valid_q;

  assign n_eff = (scale_i > 6'(rmat_pkg::MaxScale)) ? 6'(rmat_pkg::MaxScale) : scale_i;
  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o.idx = idx_q;
    cmd_o.clear = 1'b0;
    cmd_o.op = rmat_pkg::OpNone;
    case (state_q)
      StIdle: begin
        cmd_o.idx = '0;
        if (in_valid_i && in_ready_o) begin
          cmd_o.clear = 1'b1;
          cmd_o.op = rmat_pkg::OpLoad;
        end
      end
      StMul:   cmd_o.op = rmat_pkg::OpInitMul;
      StInit:  cmd_o.op = rmat_pkg::OpInitWr;
      StTwRd:  cmd_o.op = rmat_pkg::OpTwistRd;
      StTwWr:  cmd_o.op = rmat_pkg::OpTwistWr;
      StDrRd:  cmd_o.op = rmat_pkg::OpDrawRd;
      StDrUse: cmd_o.op = rmat_pkg::OpDrawUse;
      default: cmd_o.op = rmat_pkg::OpNone;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && in_ready_o) begin
          idx_q <= 9'd1;
          state_q <= StMul;
        end
        StMul: state_q <= StInit;
        StInit: begin
          if (idx_q == 9'(rmat_pkg::TwN - 1)) begin
            idx_q <= '0;
            state_q <= StTwRd;
          end else begin
            idx_q <= idx_q + 9'd1;
            state_q <= StMul;
          end
        end
        StTwRd: state_q <= StTwWr;
        StTwWr: begin
          if (idx_q == 9'(rmat_pkg::TwN - 1)) begin
            idx_q <= '0;
            left_q <= n_eff;
            state_q <= (n_eff == 6'd0) ? StDone : StDrRd;
          end else begin
            idx_q <= idx_q + 9'd1;
            state_q <= StTwRd;
          end
        end
        StDrRd: state_q <= StDrUse;
        StDrUse: begin
          idx_q <= idx_q + 9'd1;
          left_q <= left_q - 6'd1;
          state_q <= (left_q == 6'd1) ? StDone : StDrRd;
        end
        StDone: begin
          out_valid_q <= !sts_i.self_edge;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== tb/rmat_edge_checker.sv =====
// checker for the r-mat edge generator: predicts edges and compares transfers
`timescale 1ns / 100ps
module rmat_edge_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // edge_index
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // low_vertex, high_vertex
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);

  // shadow copy of the configuration
  logic [63:0]                 seed_q, thr_a_q, thr_ab_q, thr_abc_q;
  logic [rmat_pkg::ScaleW-1:0] scale_q;

  // predicted edges, {high_vertex, low_vertex}
  logic [63:0] edge_expect_q[$];
  logic [63:0] twister[rmat_pkg::TwN];

  assign pending_o = edge_expect_q.size();

  // mersenne twister seeding and twist
  function automatic void twister_load(input logic [63:0] s);
    logic [63:0] p, y, v;
    twister[0] = s;
    for (int i = 1; i < rmat_pkg::TwN; i++) begin
      p = twister[i-1];
      twister[i] = rmat_pkg::TwInitMul * (p ^ (p >> 62)) + 64'(i);
    end
    for (int i = 0; i < rmat_pkg::TwN; i++) begin
      y = (twister[i] & rmat_pkg::TwUpper) |
          (twister[(i+1) % rmat_pkg::TwN] & rmat_pkg::TwLower);
      v = twister[(i+rmat_pkg::TwM) % rmat_pkg::TwN] ^ (y >> 1);
      if (y[0]) v ^= rmat_pkg::TwMatrix;
      twister[i] = v;
    end
  endfunction

  // compute the edge for one index; returns 0 for a self edge
  function automatic bit rmat_edge_of(input logic [63:0] idx, output logic [63:0] pair);
    logic [63:0] src, dst, x;
    int          n;
    src = '0;
    dst = '0;
    n = (scale_q > rmat_pkg::MaxScale) ? rmat_pkg::MaxScale : int'(scale_q);
    twister_load(seed_q + idx);
    for (int i = 0; i < n; i++) begin
      x = twister[i];
      x ^= (x >> 29) & 64'h5555555555555555;
      x ^= (x << 17) & 64'h71D67FFFEDA60000;
      x ^= (x << 37) & 64'hFFF7EEE000000000;
      x ^= x >> 43;
      src <<= 1;
      dst <<= 1;
      if (x <= thr_a_q) begin
      end else if (x <= thr_ab_q) begin
        dst[0] = 1'b1;
      end else if (x <= thr_abc_q) begin
        src[0] = 1'b1;
      end else begin
        src[0] = 1'b1;
        dst[0] = 1'b1;
      end
    end
    if (src == dst) return 1'b0;
    if (src > dst) pair = {src[31:0], dst[31:0]};
    else pair = {dst[31:0], src[31:0]};
    return 1'b1;
  endfunction

  // watch config writes, input transfers and result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] pair, want;
    if (!rst_ni) begin
      seed_q    <= '0;
      scale_q   <= 6'd16;
      thr_a_q   <= 64'd10514644122014444421;
      thr_ab_q  <= 64'd14019525496019259228;
      thr_abc_q <= 64'd17524406870024074035;
      errors_o  <= 0;
      edge_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
        case (paddr[5:3])
          rmat_pkg::RegSeed:   seed_q <= pwdata;
          rmat_pkg::RegScale:  scale_q <= pwdata[rmat_pkg::ScaleW-1:0];
          rmat_pkg::RegThrA:   thr_a_q <= pwdata;
          rmat_pkg::RegThrAb:  thr_ab_q <= pwdata;
          rmat_pkg::RegThrAbc: thr_abc_q <= pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (rmat_edge_of(s_axis_tdata, pair)) edge_expect_q.push_back(pair);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (edge_expect_q.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected edge transfer: low %h high %h",
                     m_axis_tdata[31:0], m_axis_tdata[63:32]);
          errors_o <= errors_o + 1;
        end else begin
          want = edge_expect_q.pop_front();
          if (want[31:0] !== m_axis_tdata[31:0] || want[63:32] !== m_axis_tdata[63:32]) begin
            if (errors_o < 10)
              $display("edge mismatch: low exp %h got %h, high exp %h got %h",
                       want[31:0], m_axis_tdata[31:0], want[63:32], m_axis_tdata[63:32]);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the r-mat edge generator
`timescale 1ns / 100ps
module testbench;

  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // edge_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // low_vertex, high_vertex
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors, pending;
  int          idle_cycles = 0;
  int          ready_hold = 0;

  always #5 clk_i = ~clk_i;

  rmat_edge_generator i_dut (.*);

  rmat_edge_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending)
  );

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(9) == 0) ready_hold <= gap_len();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // register write: setup then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] s, input logic [63:0] sc,
                            input logic [63:0] a, input logic [63:0] ab,
                            input logic [63:0] abc);
    reg_write(rmat_pkg::RegSeed, s);
    reg_write(rmat_pkg::RegScale, sc);
    reg_write(rmat_pkg::RegThrA, a);
    reg_write(rmat_pkg::RegThrAb, ab);
    reg_write(rmat_pkg::RegThrAbc, abc);
  endtask

  // wait for all edges, then let a possible self-edge item finish
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one edge index transfer with a random gap ahead of it
  task automatic send_index(input logic [63:0] idx);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
  endtask

  // random thresholds, usually ordered
  task automatic random_phase(input int count);
    logic [63:0] t[3], tmp;
    logic [63:0] sc, idx;
    for (int i = 0; i < 3; i++) t[i] = rand64();
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2 - i; j++)
          if (t[j] > t[j+1]) begin
            tmp = t[j]; t[j] = t[j+1]; t[j+1] = tmp;
          end
    end
    sc = ($urandom_range(4) == 0) ? 64'($urandom_range(33, 63)) : 64'($urandom_range(1, 32));
    sc[63:6] = rand64() >> 6;
    set_config(rand64(), sc, t[0], t[1], t[2]);
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(1) != 0) ? rand64() : 64'($urandom_range(1000));
      send_index(idx);
    end
    end_burst();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset configuration, index extremes
    send_index(64'd0);
    send_index('1);
    send_index(64'd1);
    send_index(64'h8000_0000_0000_0000);
    end_burst();
    drain();

    // seed wraps past 2^64; write to an unused address is ignored
    set_config('1, 64'd32, 64'd10514644122014444421, 64'd14019525496019259228,
               64'd17524406870024074035);
    reg_write(3'd5, 64'd3);
    reg_write(3'd7, '1);
    send_index(64'd1);
    send_index(64'd2);
    send_index('1);
    end_burst();
    drain();

    // scale zero gives a self edge, scale above max saturates, scale one
    set_config(64'h1234, 64'd0, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000,
               64'hC000_0000_0000_0000);
    send_index(64'd5);
    send_index(64'd6);
    end_burst();
    drain();
    reg_write(rmat_pkg::RegScale, 64'd63);
    send_index(64'd5);
    send_index(64'd6);
    end_burst();
    drain();
    reg_write(rmat_pkg::RegScale, 64'd1);
    for (int i = 0; i < 6; i++) send_index(64'(i));
    end_burst();
    drain();

    // all-zero thresholds pick quadrant 11 unless the word is zero: self edges only
    set_config(64'd99, 64'd8, '0, '0, '0);
    send_index(64'd1);
    send_index(64'd2);
    end_burst();
    drain();
    // all-ones thresholds: quadrant 00 always
    set_config(64'd99, 64'd8, '1, '1, '1);
    send_index(64'd3);
    end_burst();
    drain();
    // unordered thresholds: first compare that holds wins
    set_config(64'd7, 64'd32, 64'd0, '1, 64'd0);
    send_index(64'd4);
    send_index('1);
    end_burst();
    drain();
    set_config(64'd7, 64'd20, 64'hC000_0000_0000_0000, 64'h1000_0000_0000_0000,
               64'hE000_0000_0000_0000);
    send_index(64'd8);
    send_index(64'd9);
    end_burst();
    drain();

    // random phases; a mid-phase pause waits for every edge to come back
    for (int p = 0; p < 8; p++) begin
      random_phase(30);
      if (p == 3) begin
        while (pending != 0) @(posedge clk_i);
      end
      random_phase(30);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rmat_pkg.sv
hw/rtl/rmat_datapath.sv
hw/rtl/rmat_ctrl.sv
hw/rtl/rmat_edge_generator.sv
tb/rmat_edge_checker.sv
tb/testbench.sv
